[design/pngu_pkg.sv]
// Package for the PNG scanline unfilter: register indexes, filter and status
// codes, image format types and the format decode function.
// No dependencies.
package pngu_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_ROW_BYTES = 8192;
  localparam int ROW_LEN_W     = $clog2(MAX_ROW_BYTES + 1);
  localparam int ROW_ADDR_W    = $clog2(MAX_ROW_BYTES);
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BIT_DEPTH    = 2'd2,
    REG_COLOR_TYPE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FILTER = 2'd1,
    ST_BAD_FORMAT = 2'd2
  } status_t;

  localparam logic [7:0] FLT_NONE  = 8'd0;
  localparam logic [7:0] FLT_SUB   = 8'd1;
  localparam logic [7:0] FLT_UP    = 8'd2;
  localparam logic [7:0] FLT_AVG   = 8'd3;
  localparam logic [7:0] FLT_PAETH = 8'd4;

  localparam logic [2:0] CT_GRAY       = 3'd0;
  localparam logic [2:0] CT_RGB        = 3'd2;
  localparam logic [2:0] CT_PALETTE    = 3'd3;
  localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
  localparam logic [2:0] CT_RGBA       = 3'd6;

  // Row geometry decoded from the format registers.
  typedef struct packed {
    logic [3:0]           bpp;
    logic [ROW_LEN_W-1:0] row_len;
    logic [15:0]          height;
    logic                 fmt_bad;
  } fmt_t;

  function automatic fmt_t fmt_decode(input logic [10:0] width,
                                      input logic [15:0] height,
                                      input logic [4:0]  depth,
                                      input logic [2:0]  ctype);
    logic [10:0] w;
    logic [6:0]  bits;
    logic        low;
    logic        d8or16;
    logic [17:0] prod;
    logic [14:0] row;
    fmt_t        f;
    w = width;
    if (width == 11'd0) begin
      w = 11'd1;
    end else if (width > 11'(MAX_WIDTH)) begin
      w = 11'(MAX_WIDTH);
    end
    low    = (depth == 5'd1) || (depth == 5'd2) || (depth == 5'd4) || (depth == 5'd8);
    d8or16 = (depth == 5'd8) || (depth == 5'd16);
    bits   = 7'd0;
    unique case (ctype)
      CT_GRAY:       bits = (low || depth == 5'd16) ? {2'b00, depth} : 7'd0;
      CT_RGB:        bits = d8or16 ? 7'({2'b00, depth} * 7'd3) : 7'd0;
      CT_PALETTE:    bits = low ? {2'b00, depth} : 7'd0;
      CT_GRAY_ALPHA: bits = d8or16 ? {1'b0, depth, 1'b0} : 7'd0;
      CT_RGBA:       bits = d8or16 ? {depth, 2'b00} : 7'd0;
      default:       bits = 7'd0;
    endcase
    f.fmt_bad = (bits == 7'd0);
    if (f.fmt_bad) begin
      bits = 7'd8;
    end
    f.bpp  = (bits < 7'd8) ? 4'd1 : bits[6:3];
    prod   = {7'b0, w} * {11'b0, bits};
    row    = 15'((prod + 18'd7) >> 3);
    f.row_len = (row > 15'(MAX_ROW_BYTES)) ? ROW_LEN_W'(MAX_ROW_BYTES)
                                           : ROW_LEN_W'(row);
    f.height  = (height == 16'd0) ? 16'd1 : height;
    return f;
  endfunction

endpackage

[design/pngu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/pngu_cfg.sv]
// Configuration registers of the PNG scanline unfilter and the registered
// row geometry decoded from them. Depends on pngu_pkg.
module pngu_cfg
  import pngu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output fmt_t                  fmt
);

  logic [10:0] width_r,  width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [4:0]  depth_r,  depth_nxt;
  logic [2:0]  ctype_r,  ctype_nxt;
  fmt_t        fmt_r;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    ctype_nxt  = ctype_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata[15:0];
        REG_BIT_DEPTH:    depth_nxt  = cfg_wdata[4:0];
        REG_COLOR_TYPE:   ctype_nxt  = cfg_wdata[2:0];
      endcase
    end
  end

  // Decode from the next values so a write is in effect for the very next byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1;
      height_r <= 16'd1;
      depth_r  <= 5'd8;
      ctype_r  <= CT_RGBA;
      fmt_r    <= fmt_decode(11'd1, 16'd1, 5'd8, CT_RGBA);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      ctype_r  <= ctype_nxt;
      fmt_r    <= fmt_decode(width_nxt, height_nxt, depth_nxt, ctype_nxt);
    end
  end

  assign fmt = fmt_r;

endmodule

[design/png_scanline_unfilter.sv]
// PNG scanline unfilter: a data byte transaction puts its result in the output register in
// the next cycle; throughput 1 byte per cycle unless the output stalls or the prefetch is
// stale; filter-type bytes give no result. The prior-row memory is read one byte ahead;
// when a configuration write moves the row position off it, input is held off to re-read.
// Synchronous active-low reset clears control state and waits for a filter byte on row 0;
// the prior-row memory is not cleared (the first row reads zero above). No clearing pass.
module png_scanline_unfilter
  import pngu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_byte,
  output logic                  out_row_last,
  output logic                  out_image_last,
  output logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  fmt_t fmt;

  pngu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fmt       (fmt)
  );

  // Paeth predictor: pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  // Row control state.
  logic                  await_r,     await_nxt;
  logic [ROW_LEN_W-1:0]  byte_pos_r,  byte_pos_nxt;
  logic [15:0]           row_count_r, row_count_nxt;
  logic [7:0]            filter_r,    filter_nxt;

  // Last eight bytes of the current row and the bytes above them.
  logic [7:0] cur_r [8];
  logic [7:0] abv_r [8];

  // Prior-row memory prefetch tracking and write forwarding.
  logic [ROW_ADDR_W-1:0] rd_addr_r;
  logic [ROW_ADDR_W-1:0] wr_addr_r;
  logic [7:0]            wr_data_r;
  logic                  wr_vld_r;
  logic [ROW_ADDR_W-1:0] raddr;
  logic [7:0]            rdata;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_pixel_r;
  logic       out_row_last_r;
  logic       out_image_last_r;
  status_t    out_status_r;

  logic                 in_fire;
  logic                 filt_fire;
  logic                 data_fire;
  logic                 rd_ok;
  logic                 out_free;
  logic [ROW_LEN_W-1:0] pos;
  logic [ROW_LEN_W-1:0] pos_nxt_clamped;
  logic                 first_row;
  logic                 has_left;
  logic [2:0]           left_idx;
  logic [7:0]           above;
  logic [7:0]           pa_a;
  logic [7:0]           pa_b;
  logic [7:0]           pa_c;
  logic [8:0]           avg_sum;
  logic [7:0]           pred;
  logic [7:0]           res;
  status_t              status;
  logic                 row_end;
  logic                 img_end;

  // Clamp the row position against the current row length.
  assign pos = (byte_pos_r >= fmt.row_len) ? fmt.row_len - 1'b1 : byte_pos_r;

  // Prefetch is good when it was issued for exactly this position.
  assign rd_ok    = (rd_addr_r == pos[ROW_ADDR_W-1:0]);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = await_r || (out_free && rd_ok);
  assign in_fire  = in_valid && in_ready;
  assign filt_fire = in_fire && await_r;
  assign data_fire = in_fire && !await_r;

  assign first_row = (row_count_r == 16'd0);
  assign has_left  = (pos >= ROW_LEN_W'(fmt.bpp));
  assign left_idx  = pos[2:0] - fmt.bpp[2:0];

  // Above byte: take the write of last cycle when the read raced it.
  assign above = first_row ? 8'd0
               : ((wr_vld_r && wr_addr_r == rd_addr_r) ? wr_data_r : rdata);
  assign pa_b  = above;
  assign pa_a  = has_left ? cur_r[left_idx] : 8'd0;
  assign pa_c  = (has_left && !first_row) ? abv_r[left_idx] : 8'd0;
  assign avg_sum = {1'b0, pa_a} + {1'b0, pa_b};

  always_comb begin
    if (fmt.fmt_bad) begin
      status = ST_BAD_FORMAT;
    end else if (filter_r > FLT_PAETH) begin
      status = ST_BAD_FILTER;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    unique case (filter_r)
      FLT_SUB:   pred = pa_a;
      FLT_UP:    pred = pa_b;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth(pa_a, pa_b, pa_c);
      default:   pred = 8'd0;
    endcase
    // Pass raw on a bad format or unknown filter.
    res = (status == ST_OK) ? in_data_byte + pred : in_data_byte;
  end

  assign row_end = (pos == fmt.row_len - 1'b1);
  assign img_end = row_end && ({1'b0, row_count_r} + 17'd1 >= {1'b0, fmt.height});

  // Next row state.
  always_comb begin
    await_nxt     = await_r;
    byte_pos_nxt  = byte_pos_r;
    row_count_nxt = row_count_r;
    filter_nxt    = filter_r;
    if (filt_fire) begin
      filter_nxt   = in_data_byte;
      await_nxt    = 1'b0;
      byte_pos_nxt = '0;
    end else if (data_fire) begin
      if (row_end) begin
        byte_pos_nxt  = '0;
        await_nxt     = 1'b1;
        row_count_nxt = img_end ? 16'd0 : row_count_r + 16'd1;
      end else begin
        byte_pos_nxt = pos + 1'b1;
      end
    end
  end

  // Prefetch the above byte for the position the next byte will use.
  assign pos_nxt_clamped = (byte_pos_nxt >= fmt.row_len) ? fmt.row_len - 1'b1 : byte_pos_nxt;
  assign raddr = pos_nxt_clamped[ROW_ADDR_W-1:0];

  pngu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prev_row (
    .clk   (clk),
    .we    (data_fire),
    .waddr (pos[ROW_ADDR_W-1:0]),
    .wdata (res),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid_nxt = data_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r     <= 1'b1;
      byte_pos_r  <= '0;
      row_count_r <= 16'd0;
      filter_r    <= FLT_NONE;
      rd_addr_r   <= '0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        cur_r[i] <= 8'd0;
        abv_r[i] <= 8'd0;
      end
    end else begin
      await_r     <= await_nxt;
      byte_pos_r  <= byte_pos_nxt;
      row_count_r <= row_count_nxt;
      filter_r    <= filter_nxt;
      rd_addr_r   <= raddr;
      wr_vld_r    <= data_fire;
      out_valid_r <= out_valid_nxt;
      if (data_fire) begin
        cur_r[pos[2:0]] <= res;
        abv_r[pos[2:0]] <= above;
      end
    end
  end

  // Payload registers: load on a data transaction, hold otherwise.
  always_ff @(posedge clk) begin
    if (data_fire) begin
      wr_addr_r        <= pos[ROW_ADDR_W-1:0];
      wr_data_r        <= res;
      out_pixel_r      <= res;
      out_row_last_r   <= row_end;
      out_image_last_r <= img_end;
      out_status_r     <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pixel_r;
  assign out_row_last   = out_row_last_r;
  assign out_image_last = out_image_last_r;
  assign out_status     = out_status_r;

endmodule

[design/pngu_checker.sv]
// Port-level checks for the PNG scanline unfilter and their bind to the top level.
// Depends on pngu_pkg and png_scanline_unfilter.
module pngu_checker
  import pngu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_byte,
  input logic       out_row_last,
  input logic       out_image_last,
  input logic [1:0] out_status
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_byte)
      && $stable(out_row_last) && $stable(out_image_last) && $stable(out_status))
    else $error("result changed while stalled");

  a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_last |-> out_row_last)
    else $error("image end without row end");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_BAD_FILTER)
      || (out_status == ST_BAD_FORMAT))
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);
